// ===== design/btb_pkg.sv =====
package btb_pkg;

   localparam int ADDR_W = 32;
   localparam int CNT_W  = 2;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  counter_type;

   localparam logic REQ_PREDICT = 1'b0;
   localparam logic REQ_UPDATE  = 1'b1;

   localparam counter_type CNT_STRONG_NOT_TAKEN = 2'd0;
   localparam counter_type CNT_WEAK_TAKEN       = 2'd2;
   localparam counter_type CNT_STRONG_TAKEN     = 2'd3;

   typedef struct packed {
      addr_type    dest;
      counter_type counter;
   } entry_data_type;

   typedef struct packed {
      logic strobe;
      logic update;
   } lookup_ctl_type;

   typedef struct packed {
      logic hit;
      logic install;
   } lookup_res_type;

endpackage

// ===== design/btb_if.sv =====
interface btb_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   btb_pkg::addr_type  branch_pc;
   btb_pkg::addr_type  branch_target;
   logic               taken;

   modport source (output valid, output req_type, output branch_pc, output branch_target,
                   output taken, input ready);
   modport sink   (input valid, input req_type, input branch_pc, input branch_target,
                   input taken, output ready);
endinterface

interface btb_rsp_if;
   logic               valid;
   logic               ready;
   btb_pkg::addr_type  predicted_target;

   modport source (output valid, output predicted_target, input ready);
   modport sink   (input valid, input predicted_target, output ready);
endinterface

// ===== design/btb_tag_array.sv =====
module btb_tag_array #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  btb_pkg::lookup_ctl_type ctl,
   input  btb_pkg::addr_type       pc,
   output btb_pkg::lookup_res_type res,
   output logic [IDX_W-1:0]        slot
);

   localparam logic [IDX_W-1:0] RANK_LAST = IDX_W'(ENTRIES - 1);

   logic [ENTRIES-1:0]      valid_ff;
   logic [ENTRIES-1:0]      valid_in;
   btb_pkg::addr_type       source_ff [ENTRIES];
   logic [IDX_W-1:0]        rank_ff   [ENTRIES];
   logic [IDX_W-1:0]        rank_in   [ENTRIES];

   logic [ENTRIES-1:0]      match;
   logic                    hit;
   logic [IDX_W-1:0]        hit_idx;
   logic [IDX_W-1:0]        hit_rank;
   logic [IDX_W-1:0]        free_idx;
   logic [IDX_W-1:0]        victim_idx;
   logic                    full;
   logic                    do_install;
   logic                    do_touch;

   always_comb begin
      hit_idx    = '0;
      hit_rank   = '0;
      victim_idx = '0;
      free_idx   = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i] = valid_ff[i] && (source_ff[i] == pc);
         if (match[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_rank = hit_rank | rank_ff[i];
         end
         if (rank_ff[i] == RANK_LAST) begin
            victim_idx = victim_idx | IDX_W'(i);
         end
      end
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end
   end

   assign hit        = |match;
   assign full       = &valid_ff;
   assign slot       = hit ? hit_idx : (full ? victim_idx : free_idx);
   assign do_install = ctl.strobe && ctl.update && !hit;
   assign do_touch   = ctl.strobe && hit;
   assign res.hit     = hit;
   assign res.install = ctl.update && !hit;

   // The chosen entry becomes most recent; entries younger than it age by one.
   // An install ages every other valid entry, the victim having been the oldest.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (do_install) begin
            if (slot == IDX_W'(i)) begin
               valid_in[i] = 1'b1;
               rank_in[i]  = '0;
            end else if (valid_ff[i]) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end else if (do_touch) begin
            if (slot == IDX_W'(i)) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (do_install && (slot == IDX_W'(i))) begin
            source_ff[i] <= pc;
         end
      end
   end

endmodule

// ===== design/btb_data_ram.sv =====
module btb_data_ram #(
   parameter int ENTRIES = 16,
   parameter int IDX_W   = 4
) (
   input  logic                    clock,
   input  logic                    wr_en,
   input  logic [IDX_W-1:0]        wr_addr,
   input  btb_pkg::entry_data_type wr_data,
   input  logic                    rd_en,
   input  logic [IDX_W-1:0]        rd_addr,
   output btb_pkg::entry_data_type rd_data_ff
);

   btb_pkg::entry_data_type mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== design/lru_branch_target_buffer.sv =====
// A predict word passes the lookup and modify stages before its result is held in the output
// register. No new word is accepted while one is in the lookup stage, owing to the associative
// lookup and the read-modify-write of the target and counter memory through its single port pair.
// Reset (synchronous) clears the valid bits, the recency ranks and the pipeline; the data
// memory is not cleared and needs no clearing pass.
module lru_branch_target_buffer #(
   parameter int ENTRIES = 16
) (
   input logic       clock,
   input logic       reset,
   btb_req_if.sink   req_bus,
   btb_rsp_if.source rsp_bus
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic                    accept;
   logic                    a_valid_ff;
   logic                    a_update_ff;
   btb_pkg::addr_type       a_pc_ff;
   btb_pkg::addr_type       a_target_ff;
   logic                    a_taken_ff;

   btb_pkg::lookup_ctl_type lookup_ctl;
   btb_pkg::lookup_res_type lookup_res;
   logic [IDX_W-1:0]        lookup_slot;

   logic                    b_valid_ff;
   logic                    b_valid_in;
   logic                    b_update_ff;
   logic                    b_hit_ff;
   logic                    b_install_ff;
   logic [IDX_W-1:0]        b_slot_ff;
   btb_pkg::addr_type       b_target_ff;
   logic                    b_taken_ff;
   logic                    b_done;

   btb_pkg::entry_data_type rd_data;
   btb_pkg::entry_data_type wr_data;
   btb_pkg::counter_type    cnt_cur;
   btb_pkg::counter_type    cnt_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   btb_pkg::addr_type       rsp_target_ff;
   btb_pkg::addr_type       rsp_target_in;

   assign b_done = b_valid_ff && (b_update_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !a_valid_ff && (!b_valid_ff || b_done);
   assign accept = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_update_ff <= (req_bus.req_type == btb_pkg::REQ_UPDATE);
         a_pc_ff     <= req_bus.branch_pc;
         a_target_ff <= req_bus.branch_target;
         a_taken_ff  <= req_bus.taken;
      end
   end

   assign lookup_ctl.strobe = a_valid_ff;
   assign lookup_ctl.update = a_update_ff;

   btb_tag_array #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_tags (
      .clock (clock),
      .reset (reset),
      .ctl   (lookup_ctl),
      .pc    (a_pc_ff),
      .res   (lookup_res),
      .slot  (lookup_slot)
   );

   assign b_valid_in = a_valid_ff || (b_valid_ff && !b_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_valid_ff) begin
         b_update_ff  <= a_update_ff;
         b_hit_ff     <= lookup_res.hit;
         b_install_ff <= lookup_res.install;
         b_slot_ff    <= lookup_slot;
         b_target_ff  <= a_target_ff;
         b_taken_ff   <= a_taken_ff;
      end
   end

   // A new entry starts weakly taken with the resolved target; a hit keeps its target.
   assign cnt_cur = b_install_ff ? btb_pkg::CNT_WEAK_TAKEN : rd_data.counter;

   always_comb begin
      if (b_taken_ff) begin
         cnt_in = (cnt_cur == btb_pkg::CNT_STRONG_TAKEN) ? cnt_cur : cnt_cur + 2'd1;
      end else begin
         cnt_in = (cnt_cur == btb_pkg::CNT_STRONG_NOT_TAKEN) ? cnt_cur : cnt_cur - 2'd1;
      end
   end

   assign wr_data.dest    = b_install_ff ? b_target_ff : rd_data.dest;
   assign wr_data.counter = cnt_in;

   btb_data_ram #(
      .ENTRIES (ENTRIES),
      .IDX_W   (IDX_W)
   ) u_data (
      .clock      (clock),
      .wr_en      (b_done && b_update_ff),
      .wr_addr    (b_slot_ff),
      .wr_data    (wr_data),
      .rd_en      (a_valid_ff),
      .rd_addr    (lookup_slot),
      .rd_data_ff (rd_data)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_target_in = rsp_target_ff;
      if (b_done && !b_update_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_target_in = (b_hit_ff && rd_data.counter[1]) ? rd_data.dest : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_target_ff <= rsp_target_in;
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.predicted_target = rsp_target_ff;

   // The lookup stage always finds the modify stage empty.
   assert property (@(posedge clock) disable iff (reset) !(a_valid_ff && b_valid_ff))
      else $error("lookup and modify stages hold words at once");

   assert property (@(posedge clock) disable iff (reset) accept |=> a_valid_ff)
      else $error("accepted word did not enter the lookup stage");

   // A new result appears only after a predict word leaves the modify stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(b_valid_ff && !b_update_ff))
      else $error("result word raised without a predict word");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

   localparam int TABLE_SLOTS    = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 310;
   localparam int POOL_SIZE      = 32;

   typedef enum int {
      PH_FREE,
      PH_SRC_IDLE,
      PH_SNK_STALL,
      PH_BOTH
   } phase_type;

   typedef struct {
      logic              req_type;
      btb_pkg::addr_type pc;
      btb_pkg::addr_type target;
      logic              taken;
      phase_type         phase;
   } btb_word_type;

   logic clock = 1'b0;
   logic reset;

   btb_req_if req_bus ();
   btb_rsp_if rsp_bus ();

   lru_branch_target_buffer #(.ENTRIES(TABLE_SLOTS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   btb_word_type         pending_words[$];
   btb_pkg::addr_type    expected_targets[$];
   phase_type            cur_phase;
   int                   failures;
   int                   quiet_cycles;
   int                   lookups, lookups_taken, trainings, evictions;

   logic                 slot_live   [TABLE_SLOTS];
   btb_pkg::addr_type    slot_pc     [TABLE_SLOTS];
   btb_pkg::addr_type    slot_target [TABLE_SLOTS];
   btb_pkg::counter_type slot_ctr    [TABLE_SLOTS];
   int unsigned          slot_age    [TABLE_SLOTS];

   // Bringing an entry to the front ages every live entry that was younger than it.
   function automatic void make_newest(input int slot);
      int unsigned age;
      age = slot_age[slot];
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_live[i] && slot_age[i] < age) begin
            slot_age[i]++;
         end
      end
      slot_age[slot] = 0;
   endfunction

   function automatic void lookup_and_train(input btb_word_type w, output bit gives,
                                            output btb_pkg::addr_type target);
      int hit_slot, free_slot, live_count, victim;
      int unsigned oldest;
      hit_slot   = -1;
      free_slot  = -1;
      live_count = 0;
      gives      = 1'b0;
      target     = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (slot_live[i]) begin
            live_count++;
            if (hit_slot < 0 && slot_pc[i] == w.pc) begin
               hit_slot = i;
            end
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (w.req_type == btb_pkg::REQ_PREDICT) begin
         gives = 1'b1;
         lookups++;
         if (hit_slot >= 0) begin
            make_newest(hit_slot);
            if (slot_ctr[hit_slot] >= btb_pkg::CNT_WEAK_TAKEN) begin
               target = slot_target[hit_slot];
               lookups_taken++;
            end
         end
         return;
      end
      trainings++;
      if (hit_slot >= 0) begin
         make_newest(hit_slot);
      end else begin
         if (free_slot >= 0) begin
            victim = free_slot;
            slot_age[victim]  = live_count;
            slot_live[victim] = 1'b1;
         end else begin
            victim = 0;
            oldest = 0;
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (slot_age[i] >= oldest) begin
                  oldest = slot_age[i];
                  victim = i;
               end
            end
            evictions++;
         end
         slot_pc[victim]     = w.pc;
         slot_target[victim] = w.target;
         slot_ctr[victim]    = btb_pkg::CNT_WEAK_TAKEN;
         make_newest(victim);
         hit_slot = victim;
      end
      if (w.taken) begin
         if (slot_ctr[hit_slot] != btb_pkg::CNT_STRONG_TAKEN) slot_ctr[hit_slot]++;
      end else begin
         if (slot_ctr[hit_slot] != btb_pkg::CNT_STRONG_NOT_TAKEN) slot_ctr[hit_slot]--;
      end
   endfunction

   task automatic queue_word(input logic req_type, input btb_pkg::addr_type pc,
                             input btb_pkg::addr_type target, input logic taken,
                             input phase_type phase);
      btb_word_type w;
      w.req_type = req_type;
      w.pc       = pc;
      w.target   = target;
      w.taken    = taken;
      w.phase    = phase;
      pending_words.push_back(w);
   endtask

   function automatic int send_gap_pct(input phase_type phase);
      case (phase)
         PH_SRC_IDLE: return 69;
         PH_BOTH:     return 6;
         default:     return 0;
      endcase
   endfunction

   function automatic int stall_pct(input phase_type phase);
      case (phase)
         PH_SNK_STALL: return 69;
         PH_BOTH:      return 6;
         default:      return 0;
      endcase
   endfunction

   always @(posedge clock) begin
      btb_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_words.size() != 0 &&
             $urandom_range(99) >= send_gap_pct(pending_words[0].phase)) begin
            w = pending_words.pop_front();
            req_bus.valid         <= 1'b1;
            req_bus.req_type      <= w.req_type;
            req_bus.branch_pc     <= w.pc;
            req_bus.branch_target <= w.target;
            req_bus.taken         <= w.taken;
            cur_phase             <= w.phase;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      btb_word_type      w;
      bit                gives;
      btb_pkg::addr_type want;
      bit                moved;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         quiet_cycles  <= 0;
      end else begin
         moved = 1'b0;
         // A result is checked before the word of this edge is trained, so the order holds.
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (expected_targets.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got %h", $time,
                        rsp_bus.predicted_target);
               failures++;
            end else begin
               want = expected_targets.pop_front();
               if (rsp_bus.predicted_target !== want) begin
                  $display("%0t: predicted_target mismatch, expected %h, got %h", $time,
                           want, rsp_bus.predicted_target);
                  failures++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            moved      = 1'b1;
            w.req_type = req_bus.req_type;
            w.pc       = req_bus.branch_pc;
            w.target   = req_bus.branch_target;
            w.taken    = req_bus.taken;
            w.phase    = cur_phase;
            lookup_and_train(w, gives, want);
            if (gives) expected_targets.push_back(want);
         end
         quiet_cycles  <= moved ? 0 : quiet_cycles + 1;
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct(cur_phase));
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      btb_pkg::addr_type pc_pool[POOL_SIZE];
      int                pool_span[4];
      btb_pkg::addr_type pc, target;
      int                pick;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.req_type      = btb_pkg::REQ_PREDICT;
      req_bus.branch_pc     = '0;
      req_bus.branch_target = '0;
      req_bus.taken         = 1'b0;
      rsp_bus.ready         = 1'b0;
      cur_phase             = PH_FREE;
      failures              = 0;
      quiet_cycles          = 0;
      lookups               = 0;
      lookups_taken         = 0;
      trainings             = 0;
      evictions             = 0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         slot_live[i]   = 1'b0;
         slot_pc[i]     = '0;
         slot_target[i] = '0;
         slot_ctr[i]    = btb_pkg::CNT_STRONG_NOT_TAKEN;
         slot_age[i]    = 0;
      end

      // Lookups in an empty table, extreme addresses, a stored target of zero,
      // a training hit that must keep its target, and saturation at both ends.
      queue_word(btb_pkg::REQ_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b1, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'h1234_5678, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b1, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b1, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b1, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h0000_0000, 32'h0000_0000, 1'b1, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'h0000_0000, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, PH_FREE);
      queue_word(btb_pkg::REQ_UPDATE,  32'h5A5A_5A5A, 32'hA5A5_A5A5, 1'b1, PH_FREE);
      queue_word(btb_pkg::REQ_PREDICT, 32'h5A5A_5A5A, 32'h0000_0000, 1'b1, PH_FREE);

      // A pool of addresses up to twice the size of the table keeps hits frequent
      // while still forcing the oldest entry out.
      pc_pool[0] = 32'h0000_0000;
      pc_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < POOL_SIZE; i++) pc_pool[i] = $urandom();
      pool_span = '{18, 16, 24, 32};
      for (int p = PH_FREE; p <= PH_BOTH; p++) begin
         repeat (RANDOM_WORDS) begin
            if ($urandom_range(99) < 85) begin
               pc = pc_pool[$urandom_range(pool_span[p] - 1)];
            end else begin
               pc = $urandom();
            end
            pick = $urandom_range(19);
            if (pick == 0) begin
               target = '0;
            end else if (pick == 1) begin
               target = '1;
            end else begin
               target = $urandom();
            end
            queue_word($urandom_range(1) ? btb_pkg::REQ_UPDATE : btb_pkg::REQ_PREDICT,
                       pc, target, logic'($urandom_range(1)), phase_type'(p));
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (pending_words.size() != 0 || req_bus.valid || expected_targets.size() != 0);
      repeat (8) @(posedge clock);

      $display("Covered %0d lookups, %0d of them returning a target, and %0d training words,",
               lookups, lookups_taken, trainings);
      $display("%0d of which replaced the oldest entry of a full table.", evictions);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
